[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

[hdl/meua_pkg.sv]
// ---------------------------------------------------------------------------
// meua_pkg
// Field widths, stream packing offsets and constants of the multi-turn
// encoder unwrapper with moving-average delta filter.
// ---------------------------------------------------------------------------
package meua_pkg;

   // Input fields
   localparam int FRAME_W = 32;
   localparam int ANGLE_W = 13;
   localparam int SPEED_W = 16;

   // Configuration register
   localparam int CAL_W = 16;
   localparam logic [CAL_W-1:0] CAL_FRAMES_RESET = 16'd50;

   // Result fields
   localparam int TURN_W = 16;
   localparam int POS_W  = 30;
   localparam int STEP_W = 14;
   localparam int MEAN_W = 14;
   localparam int DEG_W  = 48;

   // Encoder geometry
   localparam int HALF_TURN = 4096;
   localparam int FULL_TURN = 8192;

   // 360/8192 degrees per count in Q16.16 is exactly 2880
   localparam int DEG_K_W = 13;
   localparam logic signed [DEG_K_W-1:0] DEG_PER_COUNT_Q16 = 13'sd2880;

   // Turn counter limits
   localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7fff;
   localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

   // Default depth of the delta ring
   localparam int AVERAGE_DEPTH_DEFAULT = 8;

   // Request tdata packing, lowest bit first
   localparam int REQ_FRAME_LSB = 0;
   localparam int REQ_ANGLE_LSB = REQ_FRAME_LSB + FRAME_W;
   localparam int REQ_SPEED_LSB = REQ_ANGLE_LSB + ANGLE_W;
   localparam int REQ_USED      = REQ_SPEED_LSB + SPEED_W;
   localparam int REQ_TDATA_W   = ((REQ_USED + 7) / 8) * 8;

   // Response tdata packing, lowest bit first
   localparam int RSP_TURN_LSB  = 0;
   localparam int RSP_POS_LSB   = RSP_TURN_LSB + TURN_W;
   localparam int RSP_STEP_LSB  = RSP_POS_LSB + POS_W;
   localparam int RSP_MEAN_LSB  = RSP_STEP_LSB + STEP_W;
   localparam int RSP_DEG_LSB   = RSP_MEAN_LSB + MEAN_W;
   localparam int RSP_SPEED_LSB = RSP_DEG_LSB + DEG_W;
   localparam int RSP_USED      = RSP_SPEED_LSB + SPEED_W;
   localparam int RSP_TDATA_W   = ((RSP_USED + 7) / 8) * 8;
   localparam int RSP_TUSER_W   = 1;

endpackage

[hdl/meua_ram.sv]
// ---------------------------------------------------------------------------
// meua_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
// ---------------------------------------------------------------------------
module meua_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/multiturn_encoder_unwrap_averager_unit.sv]
// ---------------------------------------------------------------------------
// multiturn_encoder_unwrap_averager_unit
// Unwraps a 13-bit absolute encoder angle into a multi-turn position,
// latches a bias during calibration frames and keeps a moving average of
// the unwrapped angle steps in a ring held in RAM.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  req_*     in         req_tvalid/req_tready  tdata: frame, angle, speed
//  rsp_*     out        rsp_tvalid/rsp_tready  tdata: results, tuser: calib
//  csr_*     in         csr_wr_en              calibration_frames
//
//  One request per cycle sustained while rsp_tready is high. The ring RAM
//  is read at acceptance and written when the request leaves the first
//  stage, with a bypass for a read of that slot. Reset is synchronous and
//  clears the ring's per-slot valid bits at once, so no clearing pass is
//  needed. With rsp_tready low the output register holds, the two inner
//  stages fill, then req_tready drops.
// ---------------------------------------------------------------------------
module multiturn_encoder_unwrap_averager_unit #(
   parameter int AVERAGE_DEPTH = meua_pkg::AVERAGE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [meua_pkg::CAL_W-1:0]         csr_wr_data,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // frame_index[31:0], angle_raw[44:32], speed_rpm[60:45], zero pad
   input  logic [meua_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // turn_count[15:0], multi_turn_position[45:16], step_delta[59:46],
   // mean_delta[73:60], angle_deg_q16[121:74], speed_out[137:122], zero pad
   output logic [meua_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // calibrating[0]
   output logic [meua_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   import meua_pkg::*;

   localparam int PW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam int MAGW  = $clog2(HALF_TURN * AVERAGE_DEPTH + 1);
   localparam int SW    = MAGW + 1;
   localparam int SHIFT = MAGW + $clog2(AVERAGE_DEPTH);
   localparam int RW    = SHIFT + 1;
   localparam int RECIP = ((1 << SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
   localparam int PRODW = MAGW + RW;
   localparam int DPW   = POS_W + DEG_K_W;
   localparam logic [PW-1:0] LAST_SLOT = PW'(AVERAGE_DEPTH - 1);

   // ---------------- handshake and stage enables ----------------
   logic en_out, en2, en1, mv1, mv2, accept;

   logic rsp_valid_ff, s1_valid_ff, s2_valid_ff;

   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || en_out;
   assign en1        = !s1_valid_ff || en2;
   assign mv2        = s2_valid_ff && en_out;
   assign mv1        = s1_valid_ff && en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;

   // ---------------- architectural state ----------------
   logic        [CAL_W-1:0]   cal_frames_ff;
   logic        [ANGLE_W-1:0] bias_ff;
   logic        [ANGLE_W-1:0] prev_ff;
   logic signed [TURN_W-1:0]  turns_ff;
   logic        [PW-1:0]      ring_pos_ff;
   logic signed [SW-1:0]      ring_sum_ff;
   logic [AVERAGE_DEPTH-1:0]  slot_valid_ff;

   // ---------------- stage 0: unwrap at acceptance ----------------
   logic        [FRAME_W-1:0] frame_s0;
   logic        [ANGLE_W-1:0] angle_s0;
   logic        [SPEED_W-1:0] speed_s0;
   logic                      calib_s0;
   logic signed [STEP_W-1:0]  diff_s0, step_s0, off_s0;
   logic signed [TURN_W-1:0]  turns_s0;
   logic signed [POS_W-1:0]   pos_s0;
   logic        [PW-1:0]      ring_pos_in;

   assign frame_s0 = req_tdata[REQ_FRAME_LSB +: FRAME_W];
   assign angle_s0 = req_tdata[REQ_ANGLE_LSB +: ANGLE_W];
   assign speed_s0 = req_tdata[REQ_SPEED_LSB +: SPEED_W];

   always_comb begin
      calib_s0 = (frame_s0 <= FRAME_W'(cal_frames_ff));
      diff_s0  = $signed({1'b0, angle_s0}) - $signed({1'b0, prev_ff});
      off_s0   = $signed({1'b0, angle_s0}) - $signed({1'b0, bias_ff});
      turns_s0 = turns_ff;
      // unwrap at half a turn, saturate the turn counter
      if (diff_s0 < -$signed(STEP_W'(HALF_TURN))) begin
         step_s0 = diff_s0 + STEP_W'(FULL_TURN);
         if (turns_ff != TURN_MAX) begin
            turns_s0 = turns_ff + 16'sd1;
         end
      end else if (diff_s0 > $signed(STEP_W'(HALF_TURN))) begin
         step_s0 = diff_s0 - STEP_W'(FULL_TURN);
         if (turns_ff != TURN_MIN) begin
            turns_s0 = turns_ff - 16'sd1;
         end
      end else begin
         step_s0 = diff_s0;
      end
      if (calib_s0) begin
         step_s0  = '0;
         turns_s0 = turns_ff;
         pos_s0   = $signed(POS_W'(angle_s0));
      end else begin
         pos_s0   = {turns_s0[TURN_W-1], turns_s0, angle_s0};
      end
      ring_pos_in = (ring_pos_ff == LAST_SLOT) ? '0 : ring_pos_ff + 1'b1;
   end

   // Update bias, previous angle, turns and ring pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff     <= '0;
         prev_ff     <= '0;
         turns_ff    <= '0;
         ring_pos_ff <= '0;
      end else if (accept) begin
         prev_ff <= angle_s0;
         if (calib_s0) begin
            bias_ff <= angle_s0;
         end else begin
            turns_ff    <= turns_s0;
            ring_pos_ff <= ring_pos_in;
         end
      end
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_frames_ff <= CAL_FRAMES_RESET;
      end else if (csr_wr_en) begin
         cal_frames_ff <= csr_wr_data;
      end
   end

   // ---------------- delta ring RAM ----------------
   logic                     rd_en, wr_en;
   logic [STEP_W-1:0]        rd_data;
   logic                     fwd_ff, rd_valid_ff;
   logic [STEP_W-1:0]        fwd_data_ff;

   logic                     s1_calib_ff;
   logic [PW-1:0]            s1_slot_ff;
   logic signed [STEP_W-1:0] s1_step_ff, s1_off_ff;
   logic signed [TURN_W-1:0] s1_turns_ff;
   logic signed [POS_W-1:0]  s1_pos_ff;
   logic [SPEED_W-1:0]       s1_speed_ff;

   assign rd_en = accept && !calib_s0;
   assign wr_en = mv1 && !s1_calib_ff;

   meua_ram #(
      .WIDTH (STEP_W),
      .DEPTH (AVERAGE_DEPTH),
      .AW    (PW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_step_ff),
      .rd_en   (rd_en),
      .rd_addr (ring_pos_ff),
      .rd_data (rd_data)
   );

   // Capture bypass and slot validity alongside the RAM read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_ff      <= wr_en && (s1_slot_ff == ring_pos_ff);
         fwd_data_ff <= s1_step_ff;
         rd_valid_ff <= slot_valid_ff[ring_pos_ff];
      end
   end

   // Mark slots written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (wr_en) begin
         slot_valid_ff[s1_slot_ff] <= 1'b1;
      end
   end

   // ---------------- stage 1 registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_calib_ff <= calib_s0;
         s1_slot_ff  <= ring_pos_ff;
         s1_step_ff  <= step_s0;
         s1_off_ff   <= off_s0;
         s1_turns_ff <= turns_s0;
         s1_pos_ff   <= pos_s0;
         s1_speed_ff <= speed_s0;
      end
   end

   // ---------------- stage 1: ring sum and angle product ----------------
   logic signed [STEP_W-1:0] old_s1;
   logic signed [SW-1:0]     sum_s1;
   logic signed [POS_W-1:0]  deg_base_s1;
   logic signed [DPW-1:0]    deg_prod_s1;
   logic        [MAGW-1:0]   mag_s1;

   always_comb begin
      if (fwd_ff) begin
         old_s1 = fwd_data_ff;
      end else if (rd_valid_ff) begin
         old_s1 = rd_data;
      end else begin
         old_s1 = '0;
      end
      sum_s1      = ring_sum_ff + SW'(s1_step_ff) - SW'(old_s1);
      mag_s1      = sum_s1[SW-1] ? MAGW'(-sum_s1) : MAGW'(sum_s1);
      deg_base_s1 = POS_W'(s1_off_ff) + {s1_turns_ff[TURN_W-1], s1_turns_ff, {ANGLE_W{1'b0}}};
      deg_prod_s1 = DPW'(deg_base_s1) * DPW'(DEG_PER_COUNT_Q16);
   end

   // Hold the running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_sum_ff <= '0;
      end else if (wr_en) begin
         ring_sum_ff <= sum_s1;
      end
   end

   // ---------------- stage 2 registers ----------------
   logic                     s2_calib_ff, s2_neg_ff;
   logic [MAGW-1:0]          s2_mag_ff;
   logic signed [STEP_W-1:0] s2_step_ff;
   logic signed [TURN_W-1:0] s2_turns_ff;
   logic signed [POS_W-1:0]  s2_pos_ff;
   logic signed [DEG_W-1:0]  s2_deg_ff;
   logic [SPEED_W-1:0]       s2_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_calib_ff <= s1_calib_ff;
         s2_neg_ff   <= sum_s1[SW-1];
         s2_mag_ff   <= mag_s1;
         s2_step_ff  <= s1_step_ff;
         s2_turns_ff <= s1_turns_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_deg_ff   <= DEG_W'(deg_prod_s1);
         s2_speed_ff <= s1_speed_ff;
      end
   end

   // ---------------- stage 2: mean by reciprocal, held values ----------------
   logic [PRODW-1:0]         quo_prod_s2;
   logic [MEAN_W-1:0]        quo_s2;
   logic signed [MEAN_W-1:0] mean_s2, mean_out;
   logic signed [DEG_W-1:0]  deg_out;
   logic [SPEED_W-1:0]       speed_out;

   logic signed [MEAN_W-1:0] held_mean_ff;
   logic signed [DEG_W-1:0]  held_deg_ff;
   logic [SPEED_W-1:0]       held_speed_ff;

   always_comb begin
      quo_prod_s2 = PRODW'(s2_mag_ff) * PRODW'(RECIP);
      quo_s2      = quo_prod_s2[SHIFT +: MEAN_W];
      mean_s2     = s2_neg_ff ? -$signed(quo_s2) : $signed(quo_s2);
      mean_out    = s2_calib_ff ? held_mean_ff  : mean_s2;
      deg_out     = s2_calib_ff ? held_deg_ff   : s2_deg_ff;
      speed_out   = s2_calib_ff ? held_speed_ff : s2_speed_ff;
   end

   // Hold the last tracking frame's mean, angle and speed
   always_ff @(posedge clock) begin
      if (reset) begin
         held_mean_ff  <= '0;
         held_deg_ff   <= '0;
         held_speed_ff <= '0;
      end else if (mv2 && !s2_calib_ff) begin
         held_mean_ff  <= mean_s2;
         held_deg_ff   <= s2_deg_ff;
         held_speed_ff <= s2_speed_ff;
      end
   end

   // ---------------- output register ----------------
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TUSER_W-1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mv2) begin
         rsp_data_ff <= {{(RSP_TDATA_W - RSP_USED){1'b0}}, speed_out, deg_out,
                         mean_out, s2_step_ff, s2_pos_ff, s2_turns_ff};
         rsp_user_ff <= RSP_TUSER_W'(s2_calib_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hdl/meua_checker.sv]
// ---------------------------------------------------------------------------
// meua_checker
// Port-level checks on the encoder unwrapper, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module meua_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [meua_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [meua_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   import meua_pkg::*;

   localparam int BIAS_HI_LSB = RSP_POS_LSB + ANGLE_W;
   localparam int BIAS_HI_MSB = RSP_POS_LSB + POS_W - 1;

   logic rsp_stall, rsp_calib;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_calib = rsp_tvalid && rsp_tuser[0];

   // A stalled response keeps its payload
   `ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_stall, rsp_tvalid && $stable({rsp_tdata, rsp_tuser}))

   // Backpressure on requests only while a response is stalled
   `ASSERT_IMPLIES(ready_cause_chk, clock, reset, !req_tready, rsp_stall)

   // A calibration response reports no step
   `ASSERT_IMPLIES(calib_step_chk, clock, reset, rsp_calib, rsp_tdata[RSP_STEP_LSB +: STEP_W] == '0)

   // A calibration response reports a bias within one turn
   `ASSERT_IMPLIES(calib_bias_chk, clock, reset, rsp_calib, rsp_tdata[BIAS_HI_MSB:BIAS_HI_LSB] == '0)

endmodule

bind multiturn_encoder_unwrap_averager_unit meua_checker u_meua_checker (.*);
